/* src/gfc_pkg.sv */
// ----------------------------------------------------------------------------
// gfc_pkg
// shared types, codes and constants of the frame compositor
// ----------------------------------------------------------------------------
package gfc_pkg;

   // default geometry and palette depth
   localparam int CanvasWidthDefault  = 320;
   localparam int CanvasHeightDefault = 240;
   localparam int PaletteDepthDefault = 256;

   // fixed field widths
   localparam int ADDR_W   = 17;
   localparam int CX_W     = 9;
   localparam int CY_W     = 8;
   localparam int COLOR_W  = 16;
   localparam int COMP_W   = 8;
   localparam int DIM_W    = 16;
   localparam int IDX9_W   = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // canvas positions carried to the back end (canvas side is at most 4096)
   localparam int POS_W = 12;

   // decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // input operations
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_PIXEL = 2'd1,
      OP_START = 2'd2
   } op_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_LEFT   = 3'd0,
      CSR_FRAME_TOP    = 3'd1,
      CSR_FRAME_WIDTH  = 3'd2,
      CSR_FRAME_HEIGHT = 3'd3,
      CSR_INTERLACED   = 3'd4,
      CSR_TRANSPARENT  = 3'd5,
      CSR_PALETTE_SIZE = 3'd6
   } csr_index_type;

   // configuration as seen by the front end
   typedef struct packed {
      logic [DIM_W-1:0]  frame_left;
      logic [DIM_W-1:0]  frame_top;
      logic [DIM_W-1:0]  frame_width;
      logic [DIM_W-1:0]  frame_height;
      logic              interlaced;
      logic [IDX9_W-1:0] transparent_index;
      logic [IDX9_W-1:0] palette_size;
   } cfg_type;

   // work kinds in the queue
   typedef enum logic {
      ENTRY_LOAD  = 1'b0,
      ENTRY_PIXEL = 1'b1
   } entry_kind_type;

   // one queue word: a palette write or a kept pixel
   typedef struct packed {
      entry_kind_type     kind;
      logic [COMP_W-1:0]  slot;
      logic [COLOR_W-1:0] color;
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
   } entry_type;

   // first row of each interlace pass
   function automatic logic [3:0] pass_start(input logic [1:0] pass);
      logic [3:0] v;
      case (pass)
         2'd0:    v = 4'd0;
         2'd1:    v = 4'd4;
         2'd2:    v = 4'd2;
         default: v = 4'd1;
      endcase
      return v;
   endfunction

   // row step of each interlace pass
   function automatic logic [3:0] pass_step(input logic [1:0] pass);
      logic [3:0] v;
      case (pass)
         2'd0, 2'd1: v = 4'd8;
         2'd2:       v = 4'd4;
         default:    v = 4'd2;
      endcase
      return v;
   endfunction

endpackage

/* src/gfc_front.sv */
// ----------------------------------------------------------------------------
// gfc_front
// accepts words, walks frame position, classifies pixels, queues work
// ----------------------------------------------------------------------------
module gfc_front
   import gfc_pkg::*;
#(
   parameter int CANVAS_WIDTH  = CanvasWidthDefault,
   parameter int CANVAS_HEIGHT = CanvasHeightDefault,
   parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              accept,
   input  logic [1:0]        operation,
   input  logic [COMP_W-1:0] entry_number,
   input  logic [COMP_W-1:0] red,
   input  logic [COMP_W-1:0] green,
   input  logic [COMP_W-1:0] blue,
   input  logic [COMP_W-1:0] pixel_index,
   output logic              push,
   output entry_type         push_entry
);

   logic [DIM_W-1:0] column_ff, column_in;
   logic [DIM_W-1:0] rows_done_ff, rows_done_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [1:0]       pass_ff, pass_in;

   logic             is_pixel;
   logic             active;
   logic [DIM_W:0]   x_full;
   logic [DIM_W:0]   y_full;
   logic [DIM_W:0]   col_inc;
   logic [DIM_W:0]   row_walk;
   logic [1:0]       pass_walk;
   logic [IDX9_W-1:0] px9;
   logic             keep;
   logic             load_ok;

   // position of this pixel on the canvas
   assign is_pixel = accept && (operation == OP_PIXEL);
   assign active   = is_pixel && (cfg.frame_width != '0)
                     && (rows_done_ff < cfg.frame_height);
   assign x_full   = {1'b0, cfg.frame_left} + {1'b0, column_ff};
   assign y_full   = {1'b0, cfg.frame_top} + {1'b0, row_ff};
   assign px9      = {1'b0, pixel_index};
   assign keep     = (x_full < (DIM_W+1)'(CANVAS_WIDTH))
                     && (y_full < (DIM_W+1)'(CANVAS_HEIGHT))
                     && (px9 != cfg.transparent_index)
                     && (px9 < cfg.palette_size)
                     && (px9 < IDX9_W'(PALETTE_DEPTH));
   assign col_inc  = {1'b0, column_ff} + 1'b1;
   assign load_ok  = (entry_number < COMP_W'(PALETTE_DEPTH - 1))
                     || (entry_number == COMP_W'(PALETTE_DEPTH - 1));

   // next row, walking past empty interlace passes
   always_comb begin
      pass_walk = pass_ff;
      if (!cfg.interlaced) begin
         row_walk = {1'b0, row_ff} + 1'b1;
      end else begin
         row_walk = {1'b0, row_ff} + (DIM_W+1)'(pass_step(pass_ff));
         for (int i = 0; i < 3; i++) begin
            if ((row_walk >= {1'b0, cfg.frame_height}) && (pass_walk != 2'd3)) begin
               pass_walk = pass_walk + 1'b1;
               row_walk  = (DIM_W+1)'(pass_start(pass_walk));
            end
         end
      end
   end

   // counter update
   always_comb begin
      column_in    = column_ff;
      rows_done_in = rows_done_ff;
      row_in       = row_ff;
      pass_in      = pass_ff;
      if (accept && (operation == OP_START)) begin
         column_in    = '0;
         rows_done_in = '0;
         row_in       = '0;
         pass_in      = '0;
      end else if (active) begin
         if (col_inc >= {1'b0, cfg.frame_width}) begin
            column_in    = '0;
            rows_done_in = rows_done_ff + 1'b1;
            row_in       = row_walk[DIM_W-1:0];
            pass_in      = pass_walk;
         end else begin
            column_in = col_inc[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         rows_done_ff <= '0;
         row_ff       <= '0;
         pass_ff      <= '0;
      end else begin
         column_ff    <= column_in;
         rows_done_ff <= rows_done_in;
         row_ff       <= row_in;
         pass_ff      <= pass_in;
      end
   end

   // work word for the back end
   always_comb begin
      push_entry.kind  = ENTRY_PIXEL;
      push_entry.slot  = pixel_index;
      push_entry.color = {red[7:3], green[7:2], blue[7:3]};
      push_entry.x     = x_full[POS_W-1:0];
      push_entry.y     = y_full[POS_W-1:0];
      push             = active && keep;
      if (accept && (operation == OP_LOAD)) begin
         push_entry.kind = ENTRY_LOAD;
         push_entry.slot = entry_number;
         push            = load_ok;
      end
   end

endmodule

/* src/gfc_queue.sv */
// ----------------------------------------------------------------------------
// gfc_queue
// short fifo between front and back end
// ----------------------------------------------------------------------------
module gfc_queue
   import gfc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      not_empty,
   output logic      full,
   output entry_type head
);

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head      = slots_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

/* src/gfc_back.sv */
// ----------------------------------------------------------------------------
// gfc_back
// palette memory, canvas address and the result register
// ----------------------------------------------------------------------------
module gfc_back
   import gfc_pkg::*;
#(
   parameter int CANVAS_WIDTH  = CanvasWidthDefault,
   parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  entry_type          head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ADDR_W-1:0]  rsp_canvas_address,
   output logic [CX_W-1:0]    rsp_canvas_x,
   output logic [CY_W-1:0]    rsp_canvas_y,
   output logic [COLOR_W-1:0] rsp_color
);

   localparam int PIDX_W = $clog2(PALETTE_DEPTH);
   localparam int PROD_W = POS_W + $clog2(CANVAS_WIDTH + 1);
   localparam int SUM_W  = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

   logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;

   logic               s1_valid_ff;
   logic [PROD_W-1:0]  s1_prod_ff;
   logic [POS_W-1:0]   s1_x_ff;
   logic [POS_W-1:0]   s1_y_ff;

   logic               out_valid_ff;
   logic [ADDR_W-1:0]  out_addr_ff;
   logic [CX_W-1:0]    out_x_ff;
   logic [CY_W-1:0]    out_y_ff;
   logic [COLOR_W-1:0] out_color_ff;

   logic               out_free;
   logic               s1_adv;
   logic [SUM_W-1:0]   addr_sum;
   logic [PIDX_W-1:0]  mem_idx;

   // stage enables
   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_adv   = !s1_valid_ff || out_free;
   assign pop      = not_empty && s1_adv;
   assign mem_idx  = head.slot[PIDX_W-1:0];

   // palette memory: loads write, pixels read
   always_ff @(posedge clock) begin
      if (pop && (head.kind == ENTRY_LOAD)) begin
         palette_mem[mem_idx] <= head.color;
      end
      if (pop && (head.kind == ENTRY_PIXEL)) begin
         rd_data_ff <= palette_mem[mem_idx];
      end
   end

   // stage one: row base product
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= pop && (head.kind == ENTRY_PIXEL);
      end
      if (pop && (head.kind == ENTRY_PIXEL)) begin
         s1_prod_ff <= PROD_W'(head.y) * PROD_W'(CANVAS_WIDTH);
         s1_x_ff    <= head.x;
         s1_y_ff    <= head.y;
      end
   end

   assign addr_sum = SUM_W'(s1_prod_ff) + SUM_W'(s1_x_ff);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (out_free && s1_valid_ff) begin
         out_addr_ff  <= addr_sum[ADDR_W-1:0];
         out_x_ff     <= s1_x_ff[CX_W-1:0];
         out_y_ff     <= s1_y_ff[CY_W-1:0];
         out_color_ff <= rd_data_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_canvas_address = out_addr_ff;
   assign rsp_canvas_x       = out_x_ff;
   assign rsp_canvas_y       = out_y_ff;
   assign rsp_color          = out_color_ff;

   // checks
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_prod_ff)))
      else $error("stage one word lost under stall");
   a_no_pop_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !pop)
      else $error("queue popped while stage one blocked");
   a_result_move: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> out_valid_ff)
      else $error("stage one word not moved to result");

endmodule

/* src/gif_frame_compositor_core.sv */
// ----------------------------------------------------------------------------
// gif_frame_compositor_core
// palette index stream to rgb565 canvas writes, with gif interlace order
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one word per handshake: a palette load, a pixel index or a
//   frame start. a word is taken at a clock edge with req_valid high and
//   req_stall low. rsp_* carries one canvas write (address, x, y, color) per
//   kept pixel; it is taken at an edge with rsp_valid high and rsp_stall low.
//   user writes csr_* frame registers only while block is idle; not enforced.
// throughput: one word per cycle while req_stall is low, set by the position
//   walker in the front end and the one-port palette memory in the back end.
// path: a kept pixel passes the queue slot, then the palette read with row
//   product, then the result register, before it shows on rsp_*. loads,
//   frame starts and dropped pixels give no result.
// stall: a four-word queue sits between front and back end. while rsp_stall
//   holds the result, the back end stops, the queue fills, and req_stall
//   rises once the queue is full; nothing is lost.
// reset: synchronous, clears counters, queue and valids; registers return to
//   zero with no transparency. the palette is undefined until loaded.
// ----------------------------------------------------------------------------
module gif_frame_compositor_core
   import gfc_pkg::*;
#(
   parameter int CANVAS_WIDTH  = CanvasWidthDefault,
   parameter int CANVAS_HEIGHT = CanvasHeightDefault,
   parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // input words
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_operation,
   input  logic [COMP_W-1:0]     req_entry_number,
   input  logic [COMP_W-1:0]     req_red,
   input  logic [COMP_W-1:0]     req_green,
   input  logic [COMP_W-1:0]     req_blue,
   input  logic [COMP_W-1:0]     req_pixel_index,
   // canvas writes
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ADDR_W-1:0]     rsp_canvas_address,
   output logic [CX_W-1:0]       rsp_canvas_x,
   output logic [CY_W-1:0]       rsp_canvas_y,
   output logic [COLOR_W-1:0]    rsp_color
);

   cfg_type   cfg_ff;
   logic      accept;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      not_empty;
   logic      full;
   entry_type head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_left        <= '0;
         cfg_ff.frame_top         <= '0;
         cfg_ff.frame_width       <= '0;
         cfg_ff.frame_height      <= '0;
         cfg_ff.interlaced        <= 1'b0;
         cfg_ff.transparent_index <= IDX9_W'(256);
         cfg_ff.palette_size      <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_FRAME_LEFT:   cfg_ff.frame_left        <= csr_wdata;
            CSR_FRAME_TOP:    cfg_ff.frame_top         <= csr_wdata;
            CSR_FRAME_WIDTH:  cfg_ff.frame_width       <= csr_wdata;
            CSR_FRAME_HEIGHT: cfg_ff.frame_height      <= csr_wdata;
            CSR_INTERLACED:   cfg_ff.interlaced        <= csr_wdata[0];
            CSR_TRANSPARENT:  cfg_ff.transparent_index <= csr_wdata[IDX9_W-1:0];
            CSR_PALETTE_SIZE: cfg_ff.palette_size      <= csr_wdata[IDX9_W-1:0];
            default: ;
         endcase
      end
   end

   // input handshake
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   gfc_front #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .accept       (accept),
      .operation    (req_operation),
      .entry_number (req_entry_number),
      .red          (req_red),
      .green        (req_green),
      .blue         (req_blue),
      .pixel_index  (req_pixel_index),
      .push         (push),
      .push_entry   (push_entry)
   );

   gfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_empty  (not_empty),
      .full       (full),
      .head       (head)
   );

   gfc_back #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .not_empty          (not_empty),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_canvas_address (rsp_canvas_address),
      .rsp_canvas_x       (rsp_canvas_x),
      .rsp_canvas_y       (rsp_canvas_y),
      .rsp_color          (rsp_color)
   );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the gif frame compositor core
// ----------------------------------------------------------------------------
// a short table of directed words opens the run, with hand-written canvas
// writes for the easy rows. random phases follow, each with its own frame
// registers. an in-bench model of the palette and the interlaced position
// walk predicts every canvas write, and a monitor compares each taken write
// with the oldest prediction. both sides idle at random, and one phase holds
// the result side off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
   import gfc_pkg::*;

   localparam int CLOCK_HALF_NS  = 5;
   localparam int RESET_CYCLES   = 10;
   localparam int CANVAS_W       = CanvasWidthDefault;
   localparam int CANVAS_H       = CanvasHeightDefault;
   localparam int PALETTE_D      = PaletteDepthDefault;
   localparam int PHASES         = 14;
   localparam int PHASE_WORDS    = 111;
   localparam int PRESSURE_PHASE = 11;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 16;
   localparam int DRAIN_LIMIT    = 100000;
   localparam int MAX_REPORTS    = 10;
   localparam int TIMEOUT_NS     = 5000000;

   // codes the package leaves unnamed
   localparam logic [1:0]           OP_NONE  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 3'd7;

   // interlace passes: first row and row step
   localparam logic [3:0] PASS_FIRST_ROW [4] = '{4'd0, 4'd4, 4'd2, 4'd1};
   localparam logic [3:0] PASS_ROW_STEP  [4] = '{4'd8, 4'd8, 4'd4, 4'd2};

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [CX_W-1:0]    x;
      logic [CY_W-1:0]    y;
      logic [COLOR_W-1:0] color;
   } canvas_write_type;

   typedef enum logic {
      ROW_WORD = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [1:0]            op;
      logic [COMP_W-1:0]     entry;
      logic [COMP_W-1:0]     red;
      logic [COMP_W-1:0]     green;
      logic [COMP_W-1:0]     blue;
      logic [COMP_W-1:0]     pixel;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      logic                  typed;
      logic                  has_write;
      canvas_write_type      write;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_operation = OP_LOAD;
   logic [COMP_W-1:0]     req_entry_number = '0;
   logic [COMP_W-1:0]     req_red = '0;
   logic [COMP_W-1:0]     req_green = '0;
   logic [COMP_W-1:0]     req_blue = '0;
   logic [COMP_W-1:0]     req_pixel_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ADDR_W-1:0]     rsp_canvas_address;
   logic [CX_W-1:0]       rsp_canvas_x;
   logic [CY_W-1:0]       rsp_canvas_y;
   logic [COLOR_W-1:0]    rsp_color;

   // frame registers as the model sees them
   logic [DIM_W-1:0]  frame_left = '0;
   logic [DIM_W-1:0]  frame_top = '0;
   logic [DIM_W-1:0]  frame_width = '0;
   logic [DIM_W-1:0]  frame_height = '0;
   logic              interlaced = 1'b0;
   logic [IDX9_W-1:0] transparent_index = 9'd256;
   logic [IDX9_W-1:0] palette_size = '0;

   // palette and walk position of the model
   logic [COLOR_W-1:0] palette_rgb565 [PALETTE_D];
   logic               palette_loaded [PALETTE_D];
   logic [COMP_W-1:0]  loaded_entries [$];
   logic [DIM_W-1:0]   col_pos = '0;
   logic [DIM_W-1:0]   rows_finished = '0;
   logic [DIM_W-1:0]   row_pos = '0;
   logic [1:0]         pass_idx = '0;

   canvas_write_type canvas_writes_due [$];
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   logic             hold_request = 1'b0;
   logic             hold_done = 1'b0;
   int               hold_left = 0;

   gif_frame_compositor_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_entry_number   (req_entry_number),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_pixel_index    (req_pixel_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_canvas_address (rsp_canvas_address),
      .rsp_canvas_x       (rsp_canvas_x),
      .rsp_canvas_y       (rsp_canvas_y),
      .rsp_color          (rsp_color)
   );

   always #(CLOCK_HALF_NS) clock = ~clock;

   // ------------------------------------------------------------------------
   // model of the compositor
   // ------------------------------------------------------------------------

   // frame still taking pixels
   function automatic logic frame_live();
      return frame_width != 0 && rows_finished < frame_height;
   endfunction

   // would this index give a canvas write at the current position
   function automatic logic pixel_kept(input logic [COMP_W-1:0] px);
      logic [31:0] x_pos;
      logic [31:0] y_pos;
      x_pos = 32'(frame_left) + 32'(col_pos);
      y_pos = 32'(frame_top) + 32'(row_pos);
      return frame_live() && x_pos < CANVAS_W && y_pos < CANVAS_H
         && {1'b0, px} != transparent_index && {1'b0, px} < palette_size
         && 32'(px) < PALETTE_D;
   endfunction

   // step to the next pixel, wrapping rows and interlace passes
   task automatic advance_position();
      logic [31:0] row;
      col_pos = col_pos + 1'b1;
      if (col_pos >= frame_width) begin
         col_pos = '0;
         rows_finished = rows_finished + 1'b1;
         row = 32'(row_pos);
         if (!interlaced) begin
            row = row + 1;
         end else begin
            row = row + 32'(PASS_ROW_STEP[pass_idx]);
            while (row >= 32'(frame_height) && pass_idx < 2'd3) begin
               pass_idx = pass_idx + 1'b1;
               row = 32'(PASS_FIRST_ROW[pass_idx]);
            end
         end
         row_pos = row[DIM_W-1:0];
      end
   endtask

   // apply one word to the model, queueing its canvas write if asked
   task automatic compose_word(input logic [1:0] op, input logic [COMP_W-1:0] e,
                               input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                               input logic [COMP_W-1:0] b, input logic [COMP_W-1:0] px,
                               input logic queue_it);
      canvas_write_type w;
      logic [31:0]      x_pos;
      logic [31:0]      y_pos;
      case (op)
         OP_LOAD: begin
            palette_rgb565[e] = {r[7:3], g[7:2], b[7:3]};
            if (!palette_loaded[e]) loaded_entries.push_back(e);
            palette_loaded[e] = 1'b1;
         end
         OP_START: begin
            col_pos = '0;
            rows_finished = '0;
            row_pos = '0;
            pass_idx = '0;
         end
         OP_PIXEL: begin
            if (frame_live()) begin
               x_pos = 32'(frame_left) + 32'(col_pos);
               y_pos = 32'(frame_top) + 32'(row_pos);
               if (pixel_kept(px) && queue_it) begin
                  w.addr  = ADDR_W'(y_pos * CANVAS_W + x_pos);
                  w.x     = CX_W'(x_pos);
                  w.y     = CY_W'(y_pos);
                  w.color = palette_rgb565[px];
                  canvas_writes_due.push_back(w);
               end
               advance_position();
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------

   // offer one word and wait until it is taken
   task automatic send_word(input logic [1:0] op, input logic [COMP_W-1:0] e,
                            input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                            input logic [COMP_W-1:0] b, input logic [COMP_W-1:0] px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_entry_number <= e;
      req_red          <= r;
      req_green        <= g;
      req_blue         <= b;
      req_pixel_index  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // let every outstanding write arrive and the pipe run dry
   task automatic quiesce();
      req_valid <= 1'b0;
      while (canvas_writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write one frame register in the block and in the model
   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FRAME_LEFT:   frame_left = val;
         CSR_FRAME_TOP:    frame_top = val;
         CSR_FRAME_WIDTH:  frame_width = val;
         CSR_FRAME_HEIGHT: frame_height = val;
         CSR_INTERLACED:   interlaced = val[0];
         CSR_TRANSPARENT:  transparent_index = val[IDX9_W-1:0];
         CSR_PALETTE_SIZE: palette_size = val[IDX9_W-1:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // directed table rows
   // ------------------------------------------------------------------------

   // word checked against the model
   function automatic plan_row_type row_word(input logic [1:0] op,
         input logic [COMP_W-1:0] e, input logic [COMP_W-1:0] r,
         input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b,
         input logic [COMP_W-1:0] px);
      plan_row_type row;
      row = '0;
      row.kind  = ROW_WORD;
      row.op    = op;
      row.entry = e;
      row.red   = r;
      row.green = g;
      row.blue  = b;
      row.pixel = px;
      return row;
   endfunction

   // word known to give no canvas write
   function automatic plan_row_type row_quiet(input logic [1:0] op,
         input logic [COMP_W-1:0] e, input logic [COMP_W-1:0] r,
         input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b,
         input logic [COMP_W-1:0] px);
      plan_row_type row;
      row = row_word(op, e, r, g, b, px);
      row.typed = 1'b1;
      return row;
   endfunction

   // pixel with its canvas write written out
   function automatic plan_row_type row_write(input logic [COMP_W-1:0] px,
         input int addr, input int x, input int y, input logic [COLOR_W-1:0] color);
      plan_row_type row;
      row = row_quiet(OP_PIXEL, '0, '0, '0, '0, px);
      row.has_write   = 1'b1;
      row.write.addr  = ADDR_W'(addr);
      row.write.x     = CX_W'(x);
      row.write.y     = CY_W'(y);
      row.write.color = color;
      return row;
   endfunction

   function automatic plan_row_type row_csr(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row = '0;
      row.kind      = ROW_CSR;
      row.reg_index = idx;
      row.reg_value = val;
      return row;
   endfunction

   // ------------------------------------------------------------------------
   // result side: stall pattern and long hold-off
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // compare each taken canvas write with the oldest prediction
   always @(posedge clock) begin
      canvas_write_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (canvas_writes_due.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected canvas write: addr %0d x %0d y %0d color %h",
                        rsp_canvas_address, rsp_canvas_x, rsp_canvas_y, rsp_color);
            mismatch_count <= mismatch_count + 1;
         end else begin
            w = canvas_writes_due.pop_front();
            if (w.addr != rsp_canvas_address || w.x != rsp_canvas_x
                || w.y != rsp_canvas_y || w.color != rsp_color) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("canvas write mismatch: expected addr %0d x %0d y %0d color %h, got addr %0d x %0d y %0d color %h",
                           w.addr, w.x, w.y, w.color, rsp_canvas_address,
                           rsp_canvas_x, rsp_canvas_y, rsp_color);
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      plan_row_type      plan [$];
      plan_row_type      row;
      logic [1:0]        op;
      logic [COMP_W-1:0] e, r, g, b, px;
      logic [DIM_W-1:0]  left, top, width, height;
      logic              ilace;
      logic [IDX9_W-1:0] transp, psize;
      logic              ignored;
      int                pick, counted, waited;

      foreach (palette_loaded[i]) begin
         palette_loaded[i] = 1'b0;
         palette_rgb565[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: zero width drops the pixel
      plan.push_back(row_quiet(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      // palette loads, colour extremes
      plan.push_back(row_quiet(OP_LOAD, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd0));
      plan.push_back(row_quiet(OP_LOAD, 8'd1, 8'h00, 8'h00, 8'h00, 8'd0));
      plan.push_back(row_quiet(OP_LOAD, 8'd255, 8'hF8, 8'h00, 8'h07, 8'd0));
      plan.push_back(row_quiet(OP_LOAD, 8'd2, 8'h07, 8'hFC, 8'hFF, 8'd0));
      plan.push_back(row_quiet(OP_LOAD, 8'd3, 8'hAA, 8'h55, 8'h33, 8'd0));
      // small progressive frame at the origin
      plan.push_back(row_csr(CSR_FRAME_WIDTH, 16'd3));
      plan.push_back(row_csr(CSR_FRAME_HEIGHT, 16'd2));
      plan.push_back(row_csr(CSR_PALETTE_SIZE, 16'd256));
      plan.push_back(row_csr(CSR_NONE, 16'hFFFF));
      plan.push_back(row_quiet(OP_START, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      plan.push_back(row_write(8'd0, 0, 0, 0, 16'hFFFF));
      plan.push_back(row_write(8'd255, 1, 1, 0, 16'hF800));
      plan.push_back(row_write(8'd1, 2, 2, 0, 16'h0000));
      plan.push_back(row_write(8'd2, 320, 0, 1, 16'h07FF));
      // transparency set mid frame, then the frame runs out
      plan.push_back(row_csr(CSR_TRANSPARENT, 16'd3));
      plan.push_back(row_quiet(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3));
      plan.push_back(row_write(8'd255, 322, 2, 1, 16'hF800));
      plan.push_back(row_quiet(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      plan.push_back(row_quiet(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      // interlaced frame at the bottom right corner, clipped
      plan.push_back(row_csr(CSR_FRAME_LEFT, 16'd318));
      plan.push_back(row_csr(CSR_FRAME_TOP, 16'd238));
      plan.push_back(row_csr(CSR_FRAME_HEIGHT, 16'd10));
      plan.push_back(row_csr(CSR_INTERLACED, 16'd1));
      plan.push_back(row_csr(CSR_PALETTE_SIZE, 16'd2));
      plan.push_back(row_csr(CSR_TRANSPARENT, 16'd256));
      plan.push_back(row_quiet(OP_START, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      plan.push_back(row_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      plan.push_back(row_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1));
      plan.push_back(row_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2));
      plan.push_back(row_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      plan.push_back(row_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1));

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            quiesce();
            set_reg(row.reg_index, row.reg_value);
         end else begin
            compose_word(row.op, row.entry, row.red, row.green, row.blue, row.pixel,
                         !row.typed);
            if (row.typed && row.has_write) canvas_writes_due.push_back(row.write);
            send_word(row.op, row.entry, row.red, row.green, row.blue, row.pixel);
         end
      end

      // random phases, each with fresh frame registers
      for (int phase = 0; phase < PHASES; phase++) begin
         quiesce();
         if (phase < 5) begin
            send_idle_pct = 17;
            recv_stall_pct <= 85;
         end else if (phase < 10) begin
            send_idle_pct = 85;
            recv_stall_pct <= 17;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
         end

         // ordinary small frame, then the phase's special twist
         pick   = $urandom_range(2);
         left   = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(319))
                                                    : 16'($urandom_range(319, 300));
         pick   = $urandom_range(2);
         top    = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(239))
                                                    : 16'($urandom_range(239, 225));
         width  = 16'($urandom_range(12, 1));
         height = 16'($urandom_range(12, 1));
         ilace  = 1'($urandom_range(1));
         transp = ($urandom_range(99) < 30) ? 9'd256 : 9'($urandom_range(255));
         psize  = ($urandom_range(99) < 40) ? 9'd256 : 9'($urandom_range(256, 1));
         case (phase)
            1: begin
               width  = 16'hFFFF;
               height = 16'd1;
            end
            2: begin
               width  = 16'd1;
               height = 16'hFFFF;
               ilace  = 1'b1;
            end
            3: left = 16'hFFFF;
            4: top = 16'hFFFF;
            5: psize = 9'd0;
            6: begin
               transp = 9'd0;
               psize  = 9'd256;
            end
            7: transp = 9'd255;
            8: width = 16'd0;
            9: height = 16'd0;
            PRESSURE_PHASE: begin
               left   = 16'd0;
               top    = 16'd0;
               width  = 16'd16;
               height = 16'd16;
               transp = 9'd256;
               psize  = 9'd256;
            end
            default: ;
         endcase
         set_reg(CSR_FRAME_LEFT, left);
         set_reg(CSR_FRAME_TOP, top);
         set_reg(CSR_FRAME_WIDTH, width);
         set_reg(CSR_FRAME_HEIGHT, height);
         set_reg(CSR_INTERLACED, 16'(ilace));
         set_reg(CSR_TRANSPARENT, 16'(transp));
         set_reg(CSR_PALETTE_SIZE, 16'(psize));
         if (phase == PRESSURE_PHASE) hold_request <= 1'b1;

         // most phases open a new frame, the rest carry on mid frame
         counted = 0;
         if (phase == PRESSURE_PHASE || $urandom_range(99) < 80) begin
            compose_word(OP_START, '0, '0, '0, '0, '0, 1'b1);
            send_word(OP_START, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
            counted++;
         end

         while (counted < PHASE_WORDS) begin
            pick = $urandom_range(99);
            op   = OP_PIXEL;
            e    = 8'($urandom);
            r    = 8'($urandom);
            g    = 8'($urandom);
            b    = 8'($urandom);
            px   = 8'($urandom);
            if (!frame_live() && pick < 60) begin
               op = OP_START;
            end else if (phase != PRESSURE_PHASE) begin
               if (pick < 12) op = OP_LOAD;
               else if (pick < 15) op = OP_START;
               else if (pick < 17) op = OP_NONE;
            end
            // never read a palette entry that was not loaded
            if (op == OP_PIXEL && pixel_kept(px) && !palette_loaded[px])
               px = loaded_entries[$urandom_range(loaded_entries.size() - 1)];
            ignored = (op == OP_NONE) || (op == OP_PIXEL && !frame_live());
            compose_word(op, e, r, g, b, px, 1'b1);
            send_word(op, e, r, g, b, px);
            if (!ignored) counted++;
         end
      end

      // drain and report
      req_valid <= 1'b0;
      for (waited = 0; waited < DRAIN_LIMIT && canvas_writes_due.size() != 0; waited++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (canvas_writes_due.size() != 0)
         $display("%0d canvas writes never arrived", canvas_writes_due.size());
      if (mismatch_count == 0 && canvas_writes_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
